// ===== rtl/nec_ir_carrier_transmitter_assert.svh =====
// Assertion macros used by the checker of the NEC IR transmitter.
`ifndef NEC_IR_CARRIER_TRANSMITTER_ASSERT_SVH
`define NEC_IR_CARRIER_TRANSMITTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define NIRCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define NIRCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/nirct_pkg.sv =====
package nirct_pkg;

    localparam int MICRO_W = 6;
    localparam int WAVE_W  = 10;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_UNIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST      = 3'd4;

    localparam logic [CFG_W-1:0] CARRIER_PERIOD_RST = 6'd26;
    localparam logic [CFG_W-1:0] ON_TIME_RST        = 6'd8;
    localparam logic [CFG_W-1:0] BURST_UNIT_RST     = 6'd21;

    typedef struct packed {
        logic [CFG_W-1:0] carrier_period_us;
        logic [CFG_W-1:0] on_time_us;
        logic [CFG_W-1:0] burst_unit_waves;
        logic             invert_output;
        logic             lsb_first;
    } cfg_t;

    typedef struct packed {
        logic led_level;
        logic busy;
    } res_t;

endpackage

// ===== rtl/nirct_frame_ctr.sv =====
module nirct_frame_ctr #(
    parameter int CODE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  nirct_pkg::cfg_t       cfg,
    input  logic                  step_en,
    input  logic                  step_start,
    input  logic [CODE_BITS-1:0]  step_code,
    output nirct_pkg::res_t       res
);
    import nirct_pkg::*;

    localparam int LAST_SEG = 2 + 2 * CODE_BITS;
    localparam int SEG_W    = $clog2(LAST_SEG + 1);
    localparam int IDX_W    = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    logic                 active_reg, active_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [SEG_W-1:0]     seg_reg, seg_next;
    logic [WAVE_W-1:0]    wave_reg, wave_next;
    logic [MICRO_W-1:0]   micro_reg, micro_next;

    logic [CFG_W-1:0]   unit_eff;
    logic [CFG_W-1:0]   period_eff;
    logic               is_mark;
    logic [SEG_W-1:0]   bit_i;
    logic               bit_in_range;
    logic [IDX_W-1:0]   bit_pos;
    logic               bit_one;
    logic [WAVE_W-1:0]  seg_waves;
    logic [MICRO_W:0]   micro_inc;
    logic [WAVE_W:0]    wave_inc;
    logic               lit_now;

    assign unit_eff   = (cfg.burst_unit_waves == '0) ? CFG_W'(1) : cfg.burst_unit_waves;
    assign period_eff = (cfg.carrier_period_us == '0) ? CFG_W'(1) : cfg.carrier_period_us;

    // Header mark is segment 0, every even segment after it is a mark too.
    assign is_mark = ~seg_reg[0];

    // Odd segments from 3 up are the variable spaces, one per code bit.
    assign bit_i        = (seg_reg - SEG_W'(3)) >> 1;
    assign bit_in_range = (seg_reg >= SEG_W'(3)) && (bit_i < SEG_W'(CODE_BITS));
    assign bit_pos      = cfg.lsb_first ? bit_i[IDX_W-1:0]
                                        : IDX_W'(CODE_BITS - 1) - bit_i[IDX_W-1:0];
    assign bit_one      = bit_in_range && code_reg[bit_pos];

    always_comb begin
        priority if (seg_reg == '0) begin
            seg_waves = {unit_eff, 4'b0000};
        end else if (seg_reg == SEG_W'(1)) begin
            seg_waves = {1'b0, unit_eff, 3'b000};
        end else if (!is_mark && bit_one) begin
            seg_waves = {4'b0000, unit_eff} + {3'b000, unit_eff, 1'b0};
        end else begin
            seg_waves = {4'b0000, unit_eff};
        end
    end

    assign micro_inc = {1'b0, micro_reg} + (MICRO_W + 1)'(1);
    assign wave_inc  = {1'b0, wave_reg} + (WAVE_W + 1)'(1);
    assign lit_now   = active_reg && is_mark && (micro_reg < cfg.on_time_us);

    always_comb begin
        active_next = active_reg;
        code_next   = code_reg;
        seg_next    = seg_reg;
        wave_next   = wave_reg;
        micro_next  = micro_reg;
        if (step_en) begin
            if (step_start) begin
                if (!active_reg) begin
                    active_next = 1'b1;
                    code_next   = step_code;
                    seg_next    = '0;
                    wave_next   = '0;
                    micro_next  = '0;
                end
            end else if (active_reg) begin
                if (micro_inc < {1'b0, period_eff}) begin
                    micro_next = micro_inc[MICRO_W-1:0];
                end else begin
                    micro_next = '0;
                    if (wave_inc < {1'b0, seg_waves}) begin
                        wave_next = wave_inc[WAVE_W-1:0];
                    end else begin
                        wave_next = '0;
                        if (seg_reg >= SEG_W'(LAST_SEG)) begin
                            active_next = 1'b0;
                            seg_next    = '0;
                        end else begin
                            seg_next = seg_reg + SEG_W'(1);
                        end
                    end
                end
            end
        end
    end

    // A start taken while idle shows the first tick of the header mark.
    always_comb begin
        if (step_start && !active_reg) begin
            res.led_level = (cfg.on_time_us != '0) ^ cfg.invert_output;
        end else begin
            res.led_level = lit_now ^ cfg.invert_output;
        end
        res.busy = active_reg || step_start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            code_reg   <= '0;
            seg_reg    <= '0;
            wave_reg   <= '0;
            micro_reg  <= '0;
        end else begin
            active_reg <= active_next;
            code_reg   <= code_next;
            seg_reg    <= seg_next;
            wave_reg   <= wave_next;
            micro_reg  <= micro_next;
        end
    end

endmodule

// ===== rtl/nec_ir_carrier_transmitter.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------
// input    | s_valid / s_ready  | s_mode, s_code[31:0]
// result   | m_valid / m_ready  | m_led_level, m_busy_res
// config   | cfg_wr_en          | cfg_index[2:0], cfg_wdata[5:0]
//
// Each item is handled at its accepting edge: the frame counters update there
// and the result is captured in the output register at that same edge.
// One item per cycle is sustained while m_ready is high; s_ready falls only
// when the output register is full and m_ready is low.
// Reset (synchronous, aresetn low) clears the frame state, empties the output
// register and restores the register defaults.
module nec_ir_carrier_transmitter #(
    parameter int CODE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_led_level,
    output logic        m_busy_res,
    input  logic        cfg_wr_en,
    input  logic [nirct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nirct_pkg::CFG_W-1:0]     cfg_wdata
);
    import nirct_pkg::*;

    cfg_t cfg_reg, cfg_next;
    res_t step_res;
    logic accept;
    logic m_valid_reg, m_valid_next;
    logic m_led_level_reg;
    logic m_busy_res_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CARRIER_PERIOD: cfg_next.carrier_period_us = cfg_wdata;
                REG_ON_TIME:        cfg_next.on_time_us        = cfg_wdata;
                REG_BURST_UNIT:     cfg_next.burst_unit_waves  = cfg_wdata;
                REG_INVERT:         cfg_next.invert_output     = cfg_wdata[0];
                REG_LSB_FIRST:      cfg_next.lsb_first         = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.carrier_period_us <= CARRIER_PERIOD_RST;
            cfg_reg.on_time_us        <= ON_TIME_RST;
            cfg_reg.burst_unit_waves  <= BURST_UNIT_RST;
            cfg_reg.invert_output     <= 1'b0;
            cfg_reg.lsb_first         <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nirct_frame_ctr #(
        .CODE_BITS(CODE_BITS)
    ) u_frame_ctr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .step_en    (accept),
        .step_start (s_mode),
        .step_code  (s_code[CODE_BITS-1:0]),
        .res        (step_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_led_level_reg <= step_res.led_level;
            m_busy_res_reg  <= step_res.busy;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_led_level = m_led_level_reg;
    assign m_busy_res  = m_busy_res_reg;

endmodule

// ===== rtl/nirct_checker.sv =====
`include "nec_ir_carrier_transmitter_assert.svh"

module nirct_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_mode,
    input logic m_valid,
    input logic m_ready,
    input logic m_led_level,
    input logic m_busy_res
);

    // The output register never blocks the input unless it is full and stalled.
    `NIRCT_ASSERT_ALWAYS(a_ready_when_free, aclk, (!m_valid || m_ready) |-> s_ready, "s_ready low while the output register can take an item")

    // Every accepted item leaves a result in the output register.
    `NIRCT_ASSERT(a_result_follows, aclk, aresetn, (s_valid && s_ready) |=> m_valid, "accepted item produced no result")

    // A start item always reports a frame in progress.
    `NIRCT_ASSERT(a_start_busy, aclk, aresetn, (s_valid && s_ready && s_mode) |=> (m_valid && m_busy_res), "start item result not busy")

    // A stalled result keeps its payload.
    `NIRCT_ASSERT(a_stall_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_led_level) && $stable(m_busy_res)), "stalled result changed")

endmodule

bind nec_ir_carrier_transmitter nirct_checker u_nirct_checker (.*);
